@@ rtl/wes_pkg.sv @@
// ---------------------------------------------------------------------------
// wes_pkg: shared types and constants of the windowed evidence scorer
// operation and decision codes, register indexes, q16 limits, input clamp
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wes_pkg;

   // q16 limits
   localparam logic [16:0] Q_ONE          = 17'd65536;
   localparam logic [16:0] Q_HIGH_QUALITY = 17'd52429;
   localparam int          MIN_WINDOW     = 8;

   // operation codes
   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_EVAL  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // decision codes
   localparam logic [1:0] DEC_NONE    = 2'd0;
   localparam logic [1:0] DEC_MONITOR = 2'd1;
   localparam logic [1:0] DEC_REVIEW  = 2'd2;
   localparam logic [1:0] DEC_ENFORCE = 2'd3;

   // register indexes
   localparam logic [2:0] REG_MONITOR  = 3'd0;
   localparam logic [2:0] REG_REVIEW   = 3'd1;
   localparam logic [2:0] REG_ENFORCE  = 3'd2;
   localparam logic [2:0] REG_SUPPORT  = 3'd3;
   localparam logic [2:0] REG_WINDOW   = 3'd4;
   localparam logic [2:0] REG_OVERFLOW = 3'd5;

   typedef struct packed {
      logic        mark;
      logic [16:0] quality;
      logic [16:0] anomaly;
   } entry_type;

   // signed q16 input clamped to 0..1.0
   function automatic logic [16:0] clamp_q16(input logic signed [17:0] raw);
      logic [16:0] res;
      if (raw[17]) begin
         res = 17'd0;
      end else if (raw[16:0] > Q_ONE) begin
         res = Q_ONE;
      end else begin
         res = raw[16:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/windowed_evidence_scorer_core.sv @@
// ---------------------------------------------------------------------------
// windowed_evidence_scorer_core: sliding window of evidence entries in one ram
// add, clear and no-op words: go from idle straight to the emit state
// evaluate: paced by the one-entry-per-cycle walk
//    of the entry ram, the registered multiply stage and the 17-step divider
// one word in work at a time; a new word is taken while a result waits
// reset: synchronous; empties window and restores registers, ram keeps contents
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_evidence_scorer_core #(
   parameter int WINDOW_DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [17:0] req_anomaly,
   input  wire logic signed [17:0] req_quality,
   input  wire logic [7:0]         req_event_code,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_decision,
   output logic [16:0]             rsp_confidence,
   output logic [6:0]              rsp_support_count,
   output logic                    rsp_integrity_flag,
   output logic [6:0]              rsp_entry_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [16:0]        csr_data
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int WGT_W = 17 + CNT_W;
   localparam int SUM_W = 33 + CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_GRADE,
      ST_EMIT
   } state_type;

   // effective window limit, 8..WINDOW_DEPTH
   function automatic logic [CNT_W-1:0] eff_limit(input logic [6:0] wl);
      logic [LIM_W-1:0] w;
      w = LIM_W'(wl);
      if (w < LIM_W'(wes_pkg::MIN_WINDOW)) begin
         w = LIM_W'(wes_pkg::MIN_WINDOW);
      end
      if (w > LIM_W'(WINDOW_DEPTH)) begin
         w = LIM_W'(WINDOW_DEPTH);
      end
      return CNT_W'(w);
   endfunction

   // ring pointer plus offset, offset never above depth
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      if (s >= (CNT_W+1)'(WINDOW_DEPTH)) begin
         s = s - (CNT_W+1)'(WINDOW_DEPTH);
      end
      return IDX_W'(s);
   endfunction

   // configuration registers
   logic [16:0] mon_thr_ff;
   logic [16:0] rev_thr_ff;
   logic [16:0] enf_thr_ff;
   logic [6:0]  min_sup_ff;
   logic [6:0]  win_lim_ff;
   logic [7:0]  ovf_code_ff;

   // control
   state_type        state_ff;
   logic [IDX_W-1:0] oldest_ff;
   logic [CNT_W-1:0] held_ff;
   logic [CNT_W-1:0] issue_cnt_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic             rd_vld_ff;
   logic             prod_vld_ff;
   logic [4:0]       div_cnt_ff;

   // result staging and output word
   logic [1:0]  res_decision_ff;
   logic [16:0] res_conf_ff;
   logic [6:0]  res_support_ff;
   logic        res_integ_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_decision_ff;
   logic [16:0] rsp_conf_ff;
   logic [6:0]  rsp_support_ff;
   logic        rsp_integ_ff;
   logic [6:0]  rsp_count_ff;

   // datapath
   wes_pkg::entry_type entry_mem [WINDOW_DEPTH];
   wes_pkg::entry_type mem_rdata_ff;
   logic [33:0]        prod_ff;
   logic [16:0]        qw_ff;
   logic [SUM_W-1:0]   wsum_ff;
   logic [WGT_W-1:0]   wgt_ff;
   logic [CNT_W-1:0]   support_ff;
   logic               integ_ff;
   logic [SUM_W-1:0]   rem_ff;
   logic [SUM_W-1:0]   dvs_ff;
   logic [16:0]        quo_ff;

   logic               req_fire;
   logic               csr_fire;
   logic [16:0]        mon_eff;
   logic [16:0]        rev_lo;
   logic [16:0]        rev_eff;
   logic [16:0]        enf_lo;
   logic [16:0]        enf_eff;
   logic [6:0]         sup_need;
   logic [CNT_W-1:0]   lim;
   logic [CNT_W-1:0]   add_keep;
   logic [IDX_W-1:0]   add_oldest;
   logic [IDX_W-1:0]   add_waddr;
   wes_pkg::entry_type add_word;
   logic               mem_we;
   logic [CNT_W-1:0]   cfg_lim;
   logic               cfg_trim;
   logic [IDX_W-1:0]   trim_oldest;
   logic               issue;
   logic               walk_done;
   logic               div_ge;
   logic [16:0]        grade_conf;
   logic [1:0]         grade_dec;
   logic               sup_ok;

   // register writes wait for an idle core and go ahead of a pending word
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decision       = rsp_decision_ff;
   assign rsp_confidence     = rsp_conf_ff;
   assign rsp_support_count  = rsp_support_ff;
   assign rsp_integrity_flag = rsp_integ_ff;
   assign rsp_entry_count    = rsp_count_ff;

   // thresholds made monotone
   always_comb begin
      mon_eff  = (mon_thr_ff > wes_pkg::Q_ONE) ? wes_pkg::Q_ONE : mon_thr_ff;
      rev_lo   = (rev_thr_ff < mon_eff) ? mon_eff : rev_thr_ff;
      rev_eff  = (rev_lo > wes_pkg::Q_ONE) ? wes_pkg::Q_ONE : rev_lo;
      enf_lo   = (enf_thr_ff < rev_eff) ? rev_eff : enf_thr_ff;
      enf_eff  = (enf_lo > wes_pkg::Q_ONE) ? wes_pkg::Q_ONE : enf_lo;
      sup_need = (min_sup_ff == 7'd0) ? 7'd1 : min_sup_ff;
   end

   // add: drop oldest when full, then append behind the newest
   always_comb begin
      lim              = eff_limit(win_lim_ff);
      add_keep         = (held_ff >= lim) ? (lim - CNT_W'(1)) : held_ff;
      add_oldest       = wrap_add(oldest_ff, held_ff - add_keep);
      add_waddr        = wrap_add(add_oldest, add_keep);
      add_word.anomaly = wes_pkg::clamp_q16(req_anomaly);
      add_word.quality = wes_pkg::clamp_q16(req_quality);
      add_word.mark    = (req_event_code == ovf_code_ff);
      mem_we           = req_fire && (req_mode == wes_pkg::MODE_ADD);
   end

   // lowering the window limit keeps only the newest entries
   always_comb begin
      cfg_lim     = eff_limit(csr_data[6:0]);
      cfg_trim    = csr_fire && (csr_index == wes_pkg::REG_WINDOW) && (held_ff > cfg_lim);
      trim_oldest = wrap_add(oldest_ff, held_ff - cfg_lim);
   end

   assign issue     = (state_ff == ST_WALK) && (issue_cnt_ff != held_ff);
   assign walk_done = (state_ff == ST_WALK) && (issue_cnt_ff == held_ff)
                      && !rd_vld_ff && !prod_vld_ff;
   assign div_ge    = (rem_ff >= dvs_ff);

   always_comb begin
      if (wgt_ff == WGT_W'(0)) begin
         grade_conf = 17'd0;
      end else if (quo_ff > wes_pkg::Q_ONE) begin
         grade_conf = wes_pkg::Q_ONE;
      end else begin
         grade_conf = quo_ff;
      end
      sup_ok = (LIM_W'(support_ff) >= LIM_W'(sup_need));
      if (grade_conf >= enf_eff && sup_ok) begin
         grade_dec = wes_pkg::DEC_ENFORCE;
      end else if (grade_conf >= rev_eff) begin
         grade_dec = wes_pkg::DEC_REVIEW;
      end else if (grade_conf >= mon_eff) begin
         grade_dec = wes_pkg::DEC_MONITOR;
      end else begin
         grade_dec = wes_pkg::DEC_NONE;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mon_thr_ff  <= 17'd0;
         rev_thr_ff  <= 17'd0;
         enf_thr_ff  <= wes_pkg::Q_ONE;
         min_sup_ff  <= 7'd1;
         win_lim_ff  <= 7'd64;
         ovf_code_ff <= 8'd0;
      end else if (csr_fire) begin
         unique case (csr_index)
            wes_pkg::REG_MONITOR:  mon_thr_ff  <= csr_data;
            wes_pkg::REG_REVIEW:   rev_thr_ff  <= csr_data;
            wes_pkg::REG_ENFORCE:  enf_thr_ff  <= csr_data;
            wes_pkg::REG_SUPPORT:  min_sup_ff  <= csr_data[6:0];
            wes_pkg::REG_WINDOW:   win_lim_ff  <= csr_data[6:0];
            wes_pkg::REG_OVERFLOW: ovf_code_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // entry ram, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[add_waddr] <= add_word;
      end
      mem_rdata_ff <= entry_mem[rd_addr_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         held_ff      <= '0;
         issue_cnt_ff <= '0;
         rd_addr_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         div_cnt_ff   <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  res_decision_ff <= wes_pkg::DEC_NONE;
                  res_conf_ff     <= 17'd0;
                  res_support_ff  <= 7'd0;
                  res_integ_ff    <= 1'b0;
                  case (req_mode)
                     wes_pkg::MODE_ADD: begin
                        oldest_ff <= add_oldest;
                        held_ff   <= add_keep + CNT_W'(1);
                        state_ff  <= ST_EMIT;
                     end
                     wes_pkg::MODE_EVAL: begin
                        issue_cnt_ff <= '0;
                        rd_addr_ff   <= oldest_ff;
                        state_ff     <= (held_ff != CNT_W'(0)) ? ST_WALK : ST_EMIT;
                     end
                     wes_pkg::MODE_CLEAR: begin
                        oldest_ff <= '0;
                        held_ff   <= '0;
                        state_ff  <= ST_EMIT;
                     end
                     default: state_ff <= ST_EMIT;
                  endcase
               end else if (cfg_trim) begin
                  oldest_ff <= trim_oldest;
                  held_ff   <= cfg_lim;
               end
            end
            ST_WALK: begin
               if (issue) begin
                  issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
                  rd_addr_ff   <= (rd_addr_ff == IDX_W'(WINDOW_DEPTH - 1)) ?
                                  '0 : rd_addr_ff + IDX_W'(1);
               end
               if (walk_done) begin
                  div_cnt_ff <= 5'd16;
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               div_cnt_ff <= div_cnt_ff - 5'd1;
               if (div_cnt_ff == 5'd0) begin
                  state_ff <= ST_GRADE;
               end
            end
            ST_GRADE: begin
               res_decision_ff <= grade_dec;
               res_conf_ff     <= grade_conf;
               res_support_ff  <= 7'(support_ff);
               res_integ_ff    <= integ_ff;
               state_ff        <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_decision_ff <= res_decision_ff;
                  rsp_conf_ff     <= res_conf_ff;
                  rsp_support_ff  <= res_support_ff;
                  rsp_integ_ff    <= res_integ_ff;
                  rsp_count_ff    <= 7'(held_ff);
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // walk accumulation and restoring divider
   always_ff @(posedge clock) begin
      if (req_fire && req_mode == wes_pkg::MODE_EVAL) begin
         wsum_ff    <= '0;
         wgt_ff     <= '0;
         support_ff <= '0;
         integ_ff   <= 1'b0;
      end else begin
         if (rd_vld_ff) begin
            prod_ff <= 34'(mem_rdata_ff.anomaly) * 34'(mem_rdata_ff.quality);
            qw_ff   <= mem_rdata_ff.quality;
            if (mem_rdata_ff.quality >= wes_pkg::Q_HIGH_QUALITY
                && mem_rdata_ff.anomaly >= rev_eff) begin
               support_ff <= support_ff + CNT_W'(1);
            end
            integ_ff <= integ_ff | mem_rdata_ff.mark;
         end
         if (prod_vld_ff) begin
            wsum_ff <= wsum_ff + SUM_W'(prod_ff);
            wgt_ff  <= wgt_ff + WGT_W'(qw_ff);
         end
      end
      if (walk_done) begin
         rem_ff <= wsum_ff;
         dvs_ff <= {wgt_ff, 16'd0};
         quo_ff <= 17'd0;
      end else if (state_ff == ST_DIV) begin
         if (div_ge) begin
            rem_ff <= rem_ff - dvs_ff;
         end
         quo_ff <= {quo_ff[15:0], div_ge};
         dvs_ff <= dvs_ff >> 1;
      end
   end

endmodule

`default_nettype wire

@@ rtl/wes_checker.sv @@
// ---------------------------------------------------------------------------
// wes_checker: port-level checks of the windowed evidence scorer
// result word stability and consistency of result fields
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wes_checker #(
   parameter int WINDOW_DEPTH = 64
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_decision,
   input wire logic [16:0] rsp_confidence,
   input wire logic [6:0]  rsp_support_count,
   input wire logic        rsp_integrity_flag,
   input wire logic [6:0]  rsp_entry_count
);

   localparam logic SMALL_WIN = (WINDOW_DEPTH < 128);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_decision)
         && $stable(rsp_confidence) && $stable(rsp_support_count)
         && $stable(rsp_integrity_flag) && $stable(rsp_entry_count))
      else $error("result word changed while stalled");

   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_confidence <= wes_pkg::Q_ONE)
      else $error("confidence above 1.0");

   a_enforce_support: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_WIN && rsp_decision == wes_pkg::DEC_ENFORCE
         |-> rsp_support_count != 7'd0)
      else $error("enforce without support");

   a_support_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_WIN |-> rsp_support_count <= rsp_entry_count)
      else $error("support above entry count");

   a_integrity_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_WIN && rsp_integrity_flag |-> rsp_entry_count != 7'd0)
      else $error("integrity flag on empty window");

endmodule

bind windowed_evidence_scorer_core wes_checker #(
   .WINDOW_DEPTH(WINDOW_DEPTH)
) u_wes_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_decision       (rsp_decision),
   .rsp_confidence     (rsp_confidence),
   .rsp_support_count  (rsp_support_count),
   .rsp_integrity_flag (rsp_integrity_flag),
   .rsp_entry_count    (rsp_entry_count)
);

`default_nettype wire

@@ dv/windowed_evidence_scorer_core_tb.sv @@
// ---------------------------------------------------------------------------
// windowed_evidence_scorer_core_tb: self-checking bench of the evidence scorer
// a clocked driver feeds add, evaluate, clear and unused-mode words and
// register writes from a queue; a scoreboard keeps its own window of entries,
// predicts every result and checks each field; both sides idle at random
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_evidence_scorer_core_tb;

   localparam int         DEPTH         = 64;
   localparam int         IDX_W         = $clog2(DEPTH);
   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam logic [2:0] REG_SPARE_A   = 3'd6;
   localparam logic [2:0] REG_SPARE_B   = 3'd7;
   localparam int         TAIL_WORDS    = 150;
   localparam int         SETTLE_CYCLES = 120;
   localparam int         RANDOM_ITEMS  = 1650;

   typedef struct {
      logic               is_reg;
      logic [1:0]         mode;
      logic signed [17:0] anomaly;
      logic signed [17:0] quality;
      logic [7:0]         event_code;
      logic [2:0]         index;
      logic [16:0]        data;
   } bus_word_type;

   typedef struct packed {
      logic [1:0]  decision;
      logic [16:0] confidence;
      logic [6:0]  support_count;
      logic        integrity_flag;
      logic [6:0]  entry_count;
   } verdict_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = '0;
   logic signed [17:0] req_anomaly = '0;
   logic signed [17:0] req_quality = '0;
   logic [7:0]         req_event_code = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_decision;
   logic [16:0]        rsp_confidence;
   logic [6:0]         rsp_support_count;
   logic               rsp_integrity_flag;
   logic [6:0]         rsp_entry_count;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [16:0]        csr_data = '0;

   bus_word_type pending_words[$];
   verdict_type  expected_verdicts[$];
   int unsigned  words_sent = 0;
   int unsigned  verdicts_seen = 0;
   int unsigned  fail_count = 0;
   int unsigned  planned_items = 0;
   logic [7:0]   planned_ovf = 8'h00;
   logic         tail_quiet = 1'b0;
   int unsigned  send_gap = 0;
   logic         send_calm = 1'b0;
   int unsigned  hold_left = 0;
   logic         recv_calm = 1'b0;
   logic         pressure_done = 1'b0;

   // scoreboard copy of the window and the registers
   wes_pkg::entry_type win_store [DEPTH];
   int unsigned        win_head = 0;
   int unsigned        win_held = 0;
   logic [16:0]        thr_monitor = '0;
   logic [16:0]        thr_review = '0;
   logic [16:0]        thr_enforce = wes_pkg::Q_ONE;
   logic [6:0]         need_support = 7'd1;
   logic [6:0]         win_limit = 7'd64;
   logic [7:0]         ovf_code = '0;

   windowed_evidence_scorer_core #(
      .WINDOW_DEPTH(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_anomaly(req_anomaly),
      .req_quality(req_quality),
      .req_event_code(req_event_code),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_decision(rsp_decision),
      .rsp_confidence(rsp_confidence),
      .rsp_support_count(rsp_support_count),
      .rsp_integrity_flag(rsp_integrity_flag),
      .rsp_entry_count(rsp_entry_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [16:0] to_unit(input logic signed [17:0] raw);
      logic [16:0] res;
      if (raw < 0) begin
         res = '0;
      end else if (raw > 18'sd65536) begin
         res = wes_pkg::Q_ONE;
      end else begin
         res = raw[16:0];
      end
      return res;
   endfunction

   function automatic int unsigned window_size();
      int unsigned lim;
      lim = 32'(win_limit);
      if (lim < 32'(wes_pkg::MIN_WINDOW)) lim = 32'(wes_pkg::MIN_WINDOW);
      if (lim > 32'(DEPTH)) lim = 32'(DEPTH);
      return lim;
   endfunction

   // keep only the newest lim entries
   task automatic trim_window(input int unsigned lim);
      if (win_held > lim) begin
         win_head = (win_head + win_held - lim) % DEPTH;
         win_held = lim;
      end
   endtask

   task automatic load_register(input logic [2:0] index, input logic [16:0] data);
      case (index)
         wes_pkg::REG_MONITOR:  thr_monitor = data;
         wes_pkg::REG_REVIEW:   thr_review = data;
         wes_pkg::REG_ENFORCE:  thr_enforce = data;
         wes_pkg::REG_SUPPORT:  need_support = data[6:0];
         wes_pkg::REG_WINDOW: begin
            win_limit = data[6:0];
            trim_window(window_size());
         end
         wes_pkg::REG_OVERFLOW: ovf_code = data[7:0];
         default: ;
      endcase
   endtask

   task automatic score_word(input bus_word_type w, output verdict_type v);
      wes_pkg::entry_type e;
      int unsigned        mon, rev, enf, need, support, k;
      longint unsigned    wsum, wgt, conf;
      logic               flag;
      v = '0;
      if (w.mode == wes_pkg::MODE_ADD) begin
         if (win_held >= window_size()) trim_window(window_size() - 1);
         e.anomaly = to_unit(w.anomaly);
         e.quality = to_unit(w.quality);
         e.mark    = (w.event_code == ovf_code);
         win_store[IDX_W'((win_head + win_held) % DEPTH)] = e;
         win_held++;
      end else if (w.mode == wes_pkg::MODE_EVAL && win_held > 0) begin
         // thresholds made monotone at each evaluate
         mon = 32'((thr_monitor > wes_pkg::Q_ONE) ? wes_pkg::Q_ONE : thr_monitor);
         rev = (32'(thr_review) < mon) ? mon : 32'(thr_review);
         if (rev > 32'(wes_pkg::Q_ONE)) rev = 32'(wes_pkg::Q_ONE);
         enf = (32'(thr_enforce) < rev) ? rev : 32'(thr_enforce);
         if (enf > 32'(wes_pkg::Q_ONE)) enf = 32'(wes_pkg::Q_ONE);
         need = (need_support == 7'd0) ? 32'd1 : 32'(need_support);
         support = 0;
         wsum = 0;
         wgt = 0;
         flag = 1'b0;
         for (k = 0; k < win_held; k++) begin
            e = win_store[IDX_W'((win_head + k) % DEPTH)];
            if (e.quality >= wes_pkg::Q_HIGH_QUALITY && e.anomaly >= rev) support++;
            wsum = wsum + 64'(e.anomaly) * 64'(e.quality);
            wgt  = wgt + 64'(e.quality);
            flag = flag | e.mark;
         end
         conf = (wgt > 0) ? wsum / wgt : 64'd0;
         if (conf > 64'(wes_pkg::Q_ONE)) conf = 64'(wes_pkg::Q_ONE);
         v.confidence     = 17'(conf);
         v.support_count  = 7'(support);
         v.integrity_flag = flag;
         if (conf >= enf && support >= need) begin
            v.decision = wes_pkg::DEC_ENFORCE;
         end else if (conf >= rev) begin
            v.decision = wes_pkg::DEC_REVIEW;
         end else if (conf >= mon) begin
            v.decision = wes_pkg::DEC_MONITOR;
         end else begin
            v.decision = wes_pkg::DEC_NONE;
         end
      end else if (w.mode == wes_pkg::MODE_CLEAR) begin
         win_held = 0;
         win_head = 0;
      end
      v.entry_count = 7'(win_held);
   endtask

   task automatic check_field(input string name, input logic [16:0] want,
                              input logic [16:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic queue_word(input logic [1:0] mode, input logic signed [17:0] anomaly,
                             input logic signed [17:0] quality, input logic [7:0] code);
      bus_word_type w;
      w.is_reg     = 1'b0;
      w.mode       = mode;
      w.anomaly    = anomaly;
      w.quality    = quality;
      w.event_code = code;
      w.index      = '0;
      w.data       = '0;
      pending_words.insert(pending_words.size(), w);
      planned_items++;
   endtask

   task automatic queue_register(input logic [2:0] index, input logic [16:0] data);
      bus_word_type w;
      w.is_reg     = 1'b1;
      w.mode       = wes_pkg::MODE_ADD;
      w.anomaly    = '0;
      w.quality    = '0;
      w.event_code = '0;
      w.index      = index;
      w.data       = data;
      pending_words.insert(pending_words.size(), w);
      if (index == wes_pkg::REG_OVERFLOW) planned_ovf = data[7:0];
   endtask

   // q16 level, mostly in range, leaning above high_lo, with edges and wild values
   function automatic logic signed [17:0] pick_level(input int unsigned high_lo);
      logic signed [17:0] v;
      case ($urandom_range(0, 9))
         0: v = 18'($urandom);
         1: begin
            case ($urandom_range(0, 7))
               0: v = 18'sh20000;
               1: v = 18'sh3FFFF;
               2: v = 18'sd0;
               3: v = 18'sd52428;
               4: v = 18'sd52429;
               5: v = 18'sd65536;
               6: v = 18'sd65537;
               default: v = 18'sh1FFFF;
            endcase
         end
         2, 3, 4: v = 18'($urandom_range(high_lo, 65536));
         default: v = 18'($urandom_range(0, 65536));
      endcase
      return v;
   endfunction

   function automatic logic [16:0] pick_register(input logic [2:0] index);
      logic [16:0] v;
      case (index)
         wes_pkg::REG_SUPPORT: begin
            case ($urandom_range(0, 5))
               0: v = 17'($urandom);
               1: v = ($urandom_range(0, 1) == 0) ? 17'd0 : 17'd64;
               2: v = 17'd127;
               default: v = 17'($urandom_range(1, 10));
            endcase
         end
         wes_pkg::REG_WINDOW: begin
            case ($urandom_range(0, 7))
               0: v = 17'($urandom);
               1: v = 17'($urandom_range(0, 7));
               2: v = 17'($urandom_range(65, 127));
               3: v = ($urandom_range(0, 1) == 0) ? 17'd8 : 17'd64;
               default: v = 17'($urandom_range(8, 64));
            endcase
         end
         wes_pkg::REG_OVERFLOW: begin
            v = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 255));
         end
         default: begin
            case ($urandom_range(0, 5))
               0: v = 17'($urandom);
               1: begin
                  case ($urandom_range(0, 2))
                     0: v = 17'd0;
                     1: v = wes_pkg::Q_ONE;
                     default: v = 17'h1FFFF;
                  endcase
               end
               default: v = 17'($urandom_range(0, 65536));
            endcase
         end
      endcase
      return v;
   endfunction

   // driver: offers the next word once the last is taken, register writes only when drained
   always @(posedge clock) begin : drive
      bus_word_type w;
      verdict_type  v;
      logic         req_wait, csr_wait;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         send_gap = 0;
         win_head = 0;
         win_held = 0;
         thr_monitor = '0;
         thr_review = '0;
         thr_enforce = wes_pkg::Q_ONE;
         need_support = 7'd1;
         win_limit = 7'd64;
         ovf_code = '0;
      end else begin
         req_wait = req_valid && !req_ready;
         csr_wait = csr_valid && !csr_ready;
         if (req_valid && req_ready) begin
            w.is_reg     = 1'b0;
            w.mode       = req_mode;
            w.anomaly    = req_anomaly;
            w.quality    = req_quality;
            w.event_code = req_event_code;
            w.index      = '0;
            w.data       = '0;
            score_word(w, v);
            expected_verdicts.insert(expected_verdicts.size(), v);
            words_sent++;
         end
         if (csr_valid && csr_ready) load_register(csr_index, csr_data);
         if ((req_valid && req_ready) || (csr_valid && csr_ready)) begin
            if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
            if (!tail_quiet && !send_calm && $urandom_range(0, 4) == 0)
               send_gap = $urandom_range(1, 18);
         end
         tail_quiet <= (pending_words.size() < TAIL_WORDS);
         if (!req_wait && !csr_wait) begin
            if (send_gap > 0 || pending_words.size() == 0 ||
                (pending_words[0].is_reg && words_sent != verdicts_seen)) begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
               csr_valid <= 1'b0;
            end else begin
               w = pending_words.pop_front();
               if (w.is_reg) begin
                  csr_valid <= 1'b1;
                  csr_index <= w.index;
                  csr_data  <= w.data;
                  req_valid <= 1'b0;
               end else begin
                  req_valid      <= 1'b1;
                  req_mode       <= w.mode;
                  req_anomaly    <= w.anomaly;
                  req_quality    <= w.quality;
                  req_event_code <= w.event_code;
                  csr_valid      <= 1'b0;
               end
            end
         end
      end
   end

   // monitor: checks each result word and paces rsp_ready
   always @(posedge clock) begin : observe
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("result word with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               check_field("decision", 17'(want.decision), 17'(rsp_decision));
               check_field("confidence", want.confidence, rsp_confidence);
               check_field("support_count", 17'(want.support_count),
                           17'(rsp_support_count));
               check_field("integrity_flag", 17'(want.integrity_flag),
                           17'(rsp_integrity_flag));
               check_field("entry_count", 17'(want.entry_count), 17'(rsp_entry_count));
            end
            verdicts_seen <= verdicts_seen + 1;
         end
         // one long hold-off while the driver keeps offering, so the input stalls
         if (!pressure_done && verdicts_seen >= 300 && req_valid && rsp_valid) begin
            pressure_done = 1'b1;
            hold_left = 400;
         end else if (hold_left == 0 && !tail_quiet) begin
            if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
            if (!recv_calm && $urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 18);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned n, r, roll, span, lvl_m, lvl_r, lvl_e;
      logic [1:0]  mode;
      logic [7:0]  code;

      // empty window, unused mode, clear of nothing
      queue_word(wes_pkg::MODE_EVAL, 18'sd0, 18'sd0, 8'h00);
      queue_word(MODE_UNUSED, 18'sh20000, 18'sh1FFFF, 8'hFF);
      queue_word(wes_pkg::MODE_CLEAR, 18'sh1FFFF, 18'sh20000, 8'h00);
      // clamp edges; code 0 matches the overflow code after reset
      queue_word(wes_pkg::MODE_ADD, 18'sd65536, 18'sd65536, 8'h00);
      queue_word(wes_pkg::MODE_ADD, 18'sh3FFFF, 18'sh1FFFF, 8'hFF);
      queue_word(wes_pkg::MODE_ADD, 18'sh20000, 18'sh20000, 8'h01);
      queue_word(wes_pkg::MODE_ADD, 18'sh1FFFF, 18'sd52429, 8'h80);
      queue_word(wes_pkg::MODE_ADD, 18'sd65537, 18'sd52428, 8'h7F);
      queue_word(wes_pkg::MODE_EVAL, 18'sd0, 18'sd0, 8'h00);
      // monitor above 1.0 pulls review and enforce up with it
      queue_register(wes_pkg::REG_MONITOR, 17'h1FFFF);
      queue_register(wes_pkg::REG_REVIEW, 17'd0);
      queue_register(wes_pkg::REG_ENFORCE, 17'd0);
      queue_register(wes_pkg::REG_SUPPORT, 17'd0);
      queue_register(wes_pkg::REG_OVERFLOW, 17'h000AA);
      queue_register(REG_SPARE_A, 17'h15A5A);
      queue_register(REG_SPARE_B, 17'h0A5A5);
      queue_word(wes_pkg::MODE_EVAL, 18'sd0, 18'sd0, 8'h00);
      // review below monitor, enforce below review
      queue_register(wes_pkg::REG_MONITOR, 17'd20000);
      queue_register(wes_pkg::REG_REVIEW, 17'd10000);
      queue_register(wes_pkg::REG_ENFORCE, 17'd5000);
      queue_register(wes_pkg::REG_SUPPORT, 17'd127);
      queue_word(wes_pkg::MODE_ADD, 18'sd40000, 18'sd52429, 8'hAA);
      queue_word(wes_pkg::MODE_EVAL, 18'sd0, 18'sd0, 8'h00);
      queue_register(wes_pkg::REG_SUPPORT, 17'h1FF81);
      queue_word(wes_pkg::MODE_EVAL, 18'sd0, 18'sd0, 8'h00);
      // weightless window
      queue_word(wes_pkg::MODE_CLEAR, 18'sd0, 18'sd0, 8'h00);
      queue_word(wes_pkg::MODE_ADD, 18'sd30000, 18'sd0, 8'h00);
      queue_word(wes_pkg::MODE_ADD, 18'sd65536, -18'sd5, 8'h00);
      queue_word(wes_pkg::MODE_EVAL, 18'sd0, 18'sd0, 8'h00);
      queue_word(wes_pkg::MODE_CLEAR, 18'sd0, 18'sd0, 8'h00);
      // lowering the limit below the held count drops the oldest
      for (n = 0; n < 10; n++)
         queue_word(wes_pkg::MODE_ADD, pick_level(40000), pick_level(52429),
                    8'($urandom));
      queue_register(wes_pkg::REG_WINDOW, 17'd0);
      queue_word(wes_pkg::MODE_EVAL, 18'sd0, 18'sd0, 8'h00);
      queue_register(wes_pkg::REG_WINDOW, 17'h1007F);

      planned_items = 0;
      while (planned_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            lvl_m = $urandom_range(0, 45000);
            lvl_r = $urandom_range(lvl_m, 60000);
            lvl_e = $urandom_range(lvl_r, 65536);
            queue_register(wes_pkg::REG_MONITOR, 17'(lvl_m));
            queue_register(wes_pkg::REG_REVIEW, 17'(lvl_r));
            queue_register(wes_pkg::REG_ENFORCE, 17'(lvl_e));
         end
         for (r = 0; r < 8; r++)
            if ($urandom_range(0, 2) == 0) queue_register(3'(r), pick_register(3'(r)));
         span = $urandom_range(40, 140);
         for (n = 0; n < span; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               mode = wes_pkg::MODE_ADD;
            end else if (roll < 97) begin
               mode = wes_pkg::MODE_EVAL;
            end else if (roll < 98) begin
               mode = wes_pkg::MODE_CLEAR;
            end else begin
               mode = MODE_UNUSED;
            end
            code = ($urandom_range(0, 9) == 0) ? planned_ovf : 8'($urandom);
            queue_word(mode, pick_level(40000), pick_level(52429), code);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0 || req_valid || csr_valid ||
             verdicts_seen != words_sent)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("%0d expected results never arrived", expected_verdicts.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
rtl/wes_pkg.sv
rtl/windowed_evidence_scorer_core.sv
rtl/wes_checker.sv
dv/windowed_evidence_scorer_core_tb.sv
